[rtl/pfam_pkg.sv]
// ----------------------------------------------------------------------------
// pfam_pkg
// Shared types and constants for the page frame allocator and mapper.
// ----------------------------------------------------------------------------
package pfam_pkg;

    // Default configuration
    localparam int FRAMES_DEF      = 32;
    localparam int DIRECTORIES_DEF = 4;

    // Fixed geometry
    localparam int ENTRIES_PER_DIR = 1024;
    localparam int PAGE_IDX_W      = 10;
    localparam int FIDX_MAX_W      = 10;   // frame index field of an entry
    localparam int CNT_MAX_W       = 11;   // holds a count up to 1024
    localparam int ENTRY_W         = 13;
    localparam int ENT_FRAME_LSB   = 3;
    localparam int GROUP_W         = 32;   // bitmap bits per scan group
    localparam int GROUP_IDX_W     = 5;

    // Request codes
    localparam logic [1:0] REQ_CHECK = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    // Entry flags: user, write, present
    localparam logic [2:0] ENT_FLAGS_URW = 3'b111;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [1:0]            dir_select;
        logic [PAGE_IDX_W-1:0] entry_idx;
        logic [9:0]            amount;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] frame;
        logic [5:0] free_frames;
    } rsp_t;

    // Commands from the sequencer to the frame pool
    typedef struct packed {
        logic                  snap;
        logic                  alloc;
        logic                  release_frame;
        logic [FIDX_MAX_W-1:0] release_idx;
    } pool_cmd_t;

    // Status from the frame pool
    typedef struct packed {
        logic                  found;
        logic [FIDX_MAX_W-1:0] alloc_idx;
        logic [CNT_MAX_W-1:0]  free_count;
        logic [CNT_MAX_W-1:0]  free_next;
    } pool_stat_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

[rtl/pfam_frame_pool.sv]
// ----------------------------------------------------------------------------
// pfam_frame_pool
// Frame bitmap, free count and a two-level first-fit search.
// ----------------------------------------------------------------------------
module pfam_frame_pool #(
    parameter int FRAMES = pfam_pkg::FRAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfam_pkg::pool_cmd_t   cmd,
    output pfam_pkg::pool_stat_t  stat
);
    import pfam_pkg::*;

    localparam int NGRP   = (FRAMES + GROUP_W - 1) / GROUP_W;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);

    logic [FRAMES-1:0]        used_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [NGRP*GROUP_W-1:0]  used_pad;
    logic [NGRP-1:0]          grp_free;
    logic [GROUP_IDX_W-1:0]   grp_low   [NGRP];
    logic [NGRP-1:0]          grp_free_reg;
    logic [GROUP_IDX_W-1:0]   grp_low_reg [NGRP];
    logic                     found;
    logic [GRP_W-1:0]         sel_grp;
    logic [FIDX_W-1:0]        alloc_idx;
    logic [FIDX_W-1:0]        rel_idx;

    // Pad the bitmap to whole groups; padding reads as used.
    for (genvar k = 0; k < NGRP * GROUP_W; k++) begin : g_pad
        if (k < FRAMES) begin : g_real
            assign used_pad[k] = used_reg[k];
        end
        else begin : g_fill
            assign used_pad[k] = 1'b1;
        end
    end

    // First level: lowest free bit inside each group.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++) begin
            grp_free[g] = 1'b0;
            grp_low[g]  = '0;
            for (int b = GROUP_W - 1; b >= 0; b--) begin
                if (!used_pad[g*GROUP_W + b]) begin
                    grp_free[g] = 1'b1;
                    grp_low[g]  = GROUP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap) begin
            grp_free_reg <= grp_free;
            grp_low_reg  <= grp_low;
        end
    end

    // Second level: lowest group that has a free frame.
    always_comb
    begin
        found   = 1'b0;
        sel_grp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                found   = 1'b1;
                sel_grp = GRP_W'(g);
            end
        end
    end

    assign alloc_idx = FIDX_W'({sel_grp, grp_low_reg[sel_grp]});
    assign rel_idx   = FIDX_W'(cmd.release_idx);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.alloc) begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.release_frame) begin
            if (count_reg != CNT_W'(FRAMES)) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg  <= FRAMES'(1);
            count_reg <= CNT_W'(FRAMES - 1);
        end
        else begin
            if (cmd.alloc) begin
                used_reg[alloc_idx] <= 1'b1;
            end
            else if (cmd.release_frame) begin
                used_reg[rel_idx] <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    assign stat.found      = found;
    assign stat.alloc_idx  = FIDX_MAX_W'(alloc_idx);
    assign stat.free_count = CNT_MAX_W'(count_reg);
    assign stat.free_next  = CNT_MAX_W'(count_next);

endmodule

[rtl/page_frame_allocator_mapper.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_mapper
// Bitmap frame allocator with first-fit search and page directory tables.
// ----------------------------------------------------------------------------
// After reset the block sweeps the directory memory to zero, one entry per
// clock; req_ready stays low during that sweep. Afterwards each request is
// first accepted and then written back: on the accept edge the addressed
// directory entry is read from the synchronous memory and the frame bitmap is
// searched per 32-frame group; on the write-back edge the lowest free group is
// picked, the entry and the bitmap are written back, and the response is
// loaded into the output register. A new request is accepted only once the
// previous one has written back, so directory accesses never overlap. A
// waiting response does not block the next accept; the write-back stage holds
// only when the output register is still full. free_frames and frame carry
// the low bits of the count and the frame index.
module page_frame_allocator_mapper #(
    parameter int FRAMES      = pfam_pkg::FRAMES_DEF,
    parameter int DIRECTORIES = pfam_pkg::DIRECTORIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pfam_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pfam_pkg::rsp_t rsp
);
    import pfam_pkg::*;

    localparam int DEPTH  = DIRECTORIES * ENTRIES_PER_DIR;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    req_t               req_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] dir_mem [DEPTH];
    logic [ADDR_W-1:0]  slot_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               accept;
    logic               fire;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  rd_addr;

    logic               dir_ok;
    logic               present;
    logic [FIDX_MAX_W-1:0] ent_frame;
    logic               ent_in_range;
    logic               do_alloc;
    logic               do_free;
    rsp_t               rsp_next;

    pool_cmd_t          pool_cmd;
    pool_stat_t         pool_stat;

    // Slot = directory * 1024 + entry index.
    assign rd_addr = ADDR_W'({req.dir_select, req.entry_idx});
    assign accept  = req_valid && req_ready;

    // ------------------------------------------------------------------
    // Sequencer: clear sweep, idle, write-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // Advance one entry per cycle until the last one is zeroed.
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Hold while the previous response still sits unread.
                if (!rsp_valid_reg || rsp_ready) begin
                    fire       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode on the registered request and entry
    // ------------------------------------------------------------------
    assign dir_ok       = {5'd0, req_reg.dir_select} < 7'(DIRECTORIES);
    assign present      = rd_data_reg[0];
    assign ent_frame    = rd_data_reg[ENTRY_W-1:ENT_FRAME_LSB];
    assign ent_in_range = {1'b0, ent_frame} < CNT_MAX_W'(FRAMES);

    assign do_alloc = (req_reg.req_type == REQ_ALLOC) && dir_ok
                      && (pool_stat.free_count != '0) && pool_stat.found;
    assign do_free  = (req_reg.req_type == REQ_FREE) && dir_ok
                      && present && ent_in_range;

    assign pool_cmd.snap          = accept;
    assign pool_cmd.alloc         = fire && do_alloc;
    assign pool_cmd.release_frame = fire && do_free;
    assign pool_cmd.release_idx   = ent_frame;

    pfam_frame_pool #(
        .FRAMES (FRAMES)
    ) u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pool_cmd),
        .stat  (pool_stat)
    );

    always_comb
    begin
        rsp_next.ok          = 1'b0;
        rsp_next.frame       = '0;
        rsp_next.free_frames = 6'(pool_stat.free_next);
        case (req_reg.req_type)
            REQ_CHECK:
            begin
                rsp_next.ok = pool_stat.free_count >= {1'b0, req_reg.amount};
            end
            REQ_ALLOC:
            begin
                if (do_alloc) begin
                    rsp_next.ok    = 1'b1;
                    rsp_next.frame = 5'(pool_stat.alloc_idx);
                end
            end
            REQ_FREE:
            begin
                if (do_free) begin
                    rsp_next.ok    = 1'b1;
                    rsp_next.frame = 5'(ent_frame);
                end
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Directory memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '0;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (fire && do_alloc) begin
            mem_we    = 1'b1;
            mem_wdata = {pool_stat.alloc_idx, ENT_FLAGS_URW};
        end
        else if (fire && do_free) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            dir_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= dir_mem[rd_addr];
            req_reg     <= req;
            slot_reg    <= rd_addr;
        end
        if (fire) begin
            rsp_reg <= rsp_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire) begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready) begin
            // Drop the response once it is taken.
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/page_frame_allocator_mapper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_mapper_test
// Self-checking bench for the frame allocator and page directory mapper.
// A directed table opens the run: reset values, count limits, an unused
// request code, a mapping, an overwrite, and frees of missing entries. A long
// random run follows that fills the frame pool to exhaustion and drains it
// again. Every response is compared with a typed table value or with a local
// model of the bitmap, the free count and the directory tables.
// ----------------------------------------------------------------------------
module page_frame_allocator_mapper_test;
    import pfam_pkg::*;

    localparam int NUM_FRAMES      = FRAMES_DEF;
    localparam int NUM_DIRS        = DIRECTORIES_DEF;
    localparam int SLOTS           = NUM_DIRS * ENTRIES_PER_DIR;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_OVERWRITES  = 6;
    localparam int P_FLAG_POS      = 0;

    // Code 3 is not a request type: the block answers it and changes nothing.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Table rows carry either a typed response or take the model's answer.
    localparam logic FIXED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        req_t r;
        logic fixed_rsp;
        rsp_t want;
    } vec_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Model of the block's state.
    logic               frame_busy [NUM_FRAMES];
    int                 free_total;
    logic [ENTRY_W-1:0] dir_mem [SLOTS];
    int                 mapped_slots[$];   // slots that hold a present entry

    rsp_t pending_rsp[$];                  // responses still owed by the block
    rsp_t rsp_want;

    int errors        = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_mapped      = 0;
    int n_unmapped    = 0;
    int n_pool_empty  = 0;
    int n_check_short = 0;

    page_frame_allocator_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold reset low after start-up, then release it on a rising edge.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Model: apply one request to the local state and return its response.
    // Out-of-range directories, entries with a frame index past the pool and
    // count saturation cannot arise with the default sizes and 2-bit select,
    // but the code follows them anyway.
    // ------------------------------------------------------------------------
    function automatic rsp_t apply_request(req_t r);
        rsp_t               o;
        int                 slot;
        int                 f;
        logic [ENTRY_W-1:0] e;
        o    = '0;
        slot = int'(r.dir_select) * ENTRIES_PER_DIR + int'(r.entry_idx);
        case (r.req_type)
            REQ_CHECK:
                o.ok = (free_total >= int'(r.amount));
            REQ_ALLOC:
                if (int'(r.dir_select) < NUM_DIRS && free_total > 0)
                begin
                    // First fit: take the lowest free frame.
                    for (f = 0; f < NUM_FRAMES && !o.ok; f++)
                    begin
                        if (!frame_busy[f])
                        begin
                            frame_busy[f] = 1'b1;
                            free_total--;
                            dir_mem[slot] = {FIDX_MAX_W'(f), ENT_FLAGS_URW};
                            o.ok          = 1'b1;
                            o.frame       = 5'(f);
                        end
                    end
                end
            REQ_FREE:
                if (int'(r.dir_select) < NUM_DIRS)
                begin
                    e = dir_mem[slot];
                    f = int'(e[ENTRY_W-1:ENT_FRAME_LSB]);
                    if (e[P_FLAG_POS] && f < NUM_FRAMES)
                    begin
                        frame_busy[f] = 1'b0;
                        if (free_total < NUM_FRAMES)
                            free_total++;
                        dir_mem[slot] = '0;
                        o.ok          = 1'b1;
                        o.frame       = 5'(f);
                    end
                end
            default:
                ;
        endcase
        o.free_frames = 6'(free_total);
        return o;
    endfunction

    function automatic vec_t make_row(logic [1:0] kind, int dsel, int pidx, int amt,
                                      logic fixed, int ok, int frm, int fr);
        vec_t v;
        v.r.req_type         = kind;
        v.r.dir_select       = 2'(dsel);
        v.r.entry_idx        = PAGE_IDX_W'(pidx);
        v.r.amount           = 10'(amt);
        v.fixed_rsp          = fixed;
        v.want.ok            = 1'(ok);
        v.want.frame         = 5'(frm);
        v.want.free_frames   = 6'(fr);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one request, hold it until accepted, then update the model and
    // queue the response it owes. Optionally drop valid for a short gap.
    // ------------------------------------------------------------------------
    task automatic issue(req_t r, logic fixed, rsp_t want, bit may_idle);
        rsp_t pred;
        bit   was_present;
        int   slot;
        int   hit;
        int   i;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);

        slot        = int'(r.dir_select) * ENTRIES_PER_DIR + int'(r.entry_idx);
        was_present = dir_mem[slot][P_FLAG_POS];
        pred        = apply_request(r);
        pending_rsp.push_back(fixed ? want : pred);
        n_sent++;

        // Track mapped slots so the generator can aim frees at real entries.
        if (r.req_type == REQ_ALLOC)
        begin
            if (pred.ok)
                n_mapped++;
            else
                n_pool_empty++;
            if (pred.ok && !was_present)
                mapped_slots.push_back(slot);
        end
        if (r.req_type == REQ_FREE && pred.ok)
        begin
            n_unmapped++;
            hit = -1;
            for (i = 0; i < mapped_slots.size(); i++)
                if (mapped_slots[i] == slot)
                    hit = i;
            if (hit >= 0)
                mapped_slots.delete(hit);
        end
        if (r.req_type == REQ_CHECK && !pred.ok)
            n_check_short++;

        // Idle after about one request in five on the request side.
        if (may_idle && $urandom_range(0, 99) < 20)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side: directed table, then random fill and drain phases.
    // ------------------------------------------------------------------------
    initial
    begin : driver
        vec_t table_q[$];
        req_t nxt;
        bit   filling;
        bit   do_alloc;
        int   overwrites;
        int   slot;
        int   pick;
        int   n;
        int   k;

        for (k = 0; k < NUM_FRAMES; k++)
            frame_busy[k] = (k == 0);
        for (k = 0; k < SLOTS; k++)
            dir_mem[k] = '0;
        free_total = NUM_FRAMES - 1;

        // kind, dir, page, amount, source, ok, frame, free count
        table_q.push_back(make_row(REQ_CHECK,  0, 0,    0,    FIXED, 1, 0, 31));
        table_q.push_back(make_row(REQ_CHECK,  1, 1,    31,   FIXED, 1, 0, 31));
        table_q.push_back(make_row(REQ_CHECK,  2, 2,    32,   FIXED, 0, 0, 31));
        table_q.push_back(make_row(REQ_CHECK,  3, 1023, 1023, FIXED, 0, 0, 31));
        table_q.push_back(make_row(REQ_UNUSED, 3, 1023, 1023, FIXED, 0, 0, 31));
        // Free of an entry that was never mapped.
        table_q.push_back(make_row(REQ_FREE,   3, 1023, 0,    FIXED, 0, 0, 31));
        table_q.push_back(make_row(REQ_ALLOC,  0, 0,    0,    FIXED, 1, 1, 30));
        table_q.push_back(make_row(REQ_ALLOC,  3, 1023, 1023, FIXED, 1, 2, 29));
        table_q.push_back(make_row(REQ_FREE,   0, 0,    0,    FIXED, 1, 1, 30));
        // The freed frame is the lowest again and must be reused.
        table_q.push_back(make_row(REQ_ALLOC,  1, 512,  0,    PREDICTED, 0, 0, 0));
        // Overwrite a present entry: its old frame leaks and stays used.
        table_q.push_back(make_row(REQ_ALLOC,  3, 1023, 0,    PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_FREE,   3, 1023, 0,    PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_FREE,   3, 1023, 0,    PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_CHECK,  2, 341,  28,   PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_CHECK,  1, 682,  29,   PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_ALLOC,  2, 341,  682,  PREDICTED, 0, 0, 0));
        table_q.push_back(make_row(REQ_FREE,   1, 512,  1023, PREDICTED, 0, 0, 0));

        while (!rst_n)
            @(posedge clk);

        foreach (table_q[k])
            issue(table_q[k].r, table_q[k].fixed_rsp, table_q[k].want, 1'b1);

        filling    = 1'b1;
        overwrites = 1;   // the table already leaked one frame
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            nxt.req_type   = REQ_CHECK;
            nxt.dir_select = 2'($urandom);
            nxt.entry_idx  = PAGE_IDX_W'($urandom);
            nxt.amount     = 10'($urandom);
            pick           = $urandom_range(0, 99);
            do_alloc       = filling ? (pick < 76) : (pick >= 76);

            if (pick < 8)
            begin
                // Half the checks land right around the current count.
                if ($urandom_range(0, 1))
                    nxt.amount = 10'(free_total + $urandom_range(0, 4) - 2);
            end
            else if (pick < 11)
                nxt.req_type = REQ_UNUSED;
            else if (pick < 16)
                nxt.req_type = REQ_FREE;   // random slot, almost never mapped
            else if (do_alloc)
            begin
                nxt.req_type = REQ_ALLOC;
                if (overwrites < MAX_OVERWRITES && mapped_slots.size() > 0
                    && $urandom_range(0, 199) == 0)
                begin
                    slot = mapped_slots[$urandom_range(0, mapped_slots.size() - 1)];
                    overwrites++;
                end
                else
                begin
                    // Aim at an empty entry so frames do not leak.
                    slot = $urandom_range(0, SLOTS - 1);
                    while (dir_mem[slot][P_FLAG_POS])
                        slot = $urandom_range(0, SLOTS - 1);
                end
                nxt.dir_select = 2'(slot / ENTRIES_PER_DIR);
                nxt.entry_idx  = PAGE_IDX_W'(slot % ENTRIES_PER_DIR);
            end
            else
            begin
                nxt.req_type = REQ_FREE;
                if (mapped_slots.size() > 0)
                begin
                    slot = mapped_slots[$urandom_range(0, mapped_slots.size() - 1)];
                    nxt.dir_select = 2'(slot / ENTRIES_PER_DIR);
                    nxt.entry_idx  = PAGE_IDX_W'(slot % ENTRIES_PER_DIR);
                end
            end

            // Keep the request side busy without gaps for a stretch.
            issue(nxt, PREDICTED, '0, !(n >= 700 && n < 900));

            // Switch to draining once the pool has run dry for a while,
            // and back to filling when the tables are empty, or now and then at random.
            if (filling && free_total == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && (mapped_slots.size() == 0 || $urandom_range(0, 99) < 2))
                filling = 1'b1;
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d frames mapped, %0d unmapped, %0d allocations with",
                 n_sent, n_mapped, n_unmapped, n_pool_empty);
        $display("the pool empty, %0d checks short; %0d responses compared, %0d mismatches.",
                 n_check_short, n_checked, errors);
        if (errors == 0)
            $display("page_frame_allocator_mapper test passed");
        else
            $display("page_frame_allocator_mapper test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: stall about one cycle in five, run clean for a stretch,
    // and once hold ready low long enough that the block backs up.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int  rx_seen;
        bit  held;
        rx_seen = 0;
        held    = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                rx_seen++;
            if (!held && rx_seen >= HOLD_OFF_AT)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                rsp_ready <= (rx_seen >= 700 && rx_seen < 900)
                             || ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------------
    // Compare each accepted response with the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response with none owed: ok=%0b frame=%0d free=%0d",
                         $time, rsp.ok, rsp.frame, rsp.free_frames);
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                n_checked++;
                if (rsp.ok !== rsp_want.ok)
                begin
                    errors++;
                    $display("%0t: ok mismatch: expected %0b, actual %0b",
                             $time, rsp_want.ok, rsp.ok);
                end
                if (rsp.frame !== rsp_want.frame)
                begin
                    errors++;
                    $display("%0t: frame mismatch: expected %0d, actual %0d",
                             $time, rsp_want.frame, rsp.frame);
                end
                if (rsp.free_frames !== rsp_want.free_frames)
                begin
                    errors++;
                    $display("%0t: free_frames mismatch: expected %0d, actual %0d",
                             $time, rsp_want.free_frames, rsp.free_frames);
                end
            end
        end
    end

    // Stop a hung run; the limit covers the clearing sweep after reset.
    initial
    begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("Timed out after %0d cycles with %0d responses owed.",
                 cyc, pending_rsp.size());
        $display("page_frame_allocator_mapper test failed");
        $finish;
    end

endmodule
